@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the polyline parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/bpp_pkg.sv @@
// ----------------------------------------------------------------------------
// bpp_pkg
// Types and constants shared by the base-36 polyline parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpp_pkg;

  localparam int COORD_W     = 11;
  localparam int OUT_DEPTH   = 4;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 48;

  localparam logic [COORD_W-1:0] MAX_X_RESET = 11'd800;
  localparam logic [COORD_W-1:0] MAX_Y_RESET = 11'd600;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  localparam logic [1:0] KIND_SEG   = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_EARLY_END = 2'd0;
  localparam logic [1:0] ERR_BLANK     = 2'd1;
  localparam logic [1:0] ERR_BAD_CHAR  = 2'd2;
  localparam logic [1:0] ERR_BOUNDS    = 2'd3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_Z_LO  = 8'h7a;
  localparam logic [7:0] CH_A_OFS = 8'h57; // 'a' - 10

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_WINDOW = 4'b0010,
    PH_AFTER  = 4'b0100,
    PH_FAILED = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] stop_x;
    logic [COORD_W-1:0] stop_y;
    logic [1:0]         error_code;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    phase_t phase;
    logic   seg_out;
  } core_status_t;

endpackage

@@ rtl/bpp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bpp_cfg_regs
// APB register file holding the canvas limits max_x and max_y.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bpp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bpp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [bpp_pkg::COORD_W-1:0]       max_x,
  output logic [bpp_pkg::COORD_W-1:0]       max_y
);
  import bpp_pkg::*;

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= MAX_X_RESET;
      max_y <= MAX_Y_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_X: max_x <= pwdata[COORD_W-1:0];
        REG_MAX_Y: max_y <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_X: prdata = CFG_DATA_W'(max_x);
      REG_MAX_Y: prdata = CFG_DATA_W'(max_y);
      default:   prdata = '0;
    endcase
  end

endmodule

@@ rtl/bpp_parse_core.sv @@
// ----------------------------------------------------------------------------
// bpp_parse_core
// Per-byte parse state and the results each byte produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpp_parse_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [7:0]                  char_code,
  input  logic                        end_of_text,
  input  logic [bpp_pkg::COORD_W-1:0] max_x,
  input  logic [bpp_pkg::COORD_W-1:0] max_y,
  output bpp_pkg::push_t              push,
  output bpp_pkg::core_status_t       status
);
  import bpp_pkg::*;

  phase_t             phase, phase_next;
  logic [2:0]         digit_count, digit_count_next;
  logic [COORD_W-1:0] acc_x, acc_x_next, acc_y, acc_y_next;
  logic [COORD_W-1:0] prev_x, prev_x_next, prev_y, prev_y_next;
  logic               saw_blank, saw_blank_next;
  logic               saw_bad_char, saw_bad_char_next;
  logic               window_continues, window_continues_next;

  logic               is_blank, is_digit, is_num, is_alpha;
  logic [7:0]         num_ofs, alpha_ofs;
  logic [5:0]         dval;
  logic               open_win, do_absorb, seg;
  logic [2:0]         base_cnt, a_cnt;
  logic [COORD_W-1:0] base_x, base_y, a_x, a_y;
  logic               base_blank, base_bad, base_cont, a_blank, a_bad;
  result_t            r_seg, r_end;

  function automatic logic [COORD_W-1:0] mac36(input logic [COORD_W-1:0] a,
                                               input logic [5:0] d);
    logic [COORD_W+5:0] sum;
    sum = {1'b0, a, 5'b0} + {4'b0, a, 2'b0} + {{(COORD_W){1'b0}}, d};
    return sum[COORD_W-1:0];
  endfunction

  assign is_blank  = (char_code == CH_SPACE) || (char_code == CH_TAB);
  assign is_num    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_alpha  = (char_code >= CH_A_LO) && (char_code <= CH_Z_LO);
  assign is_digit  = is_num || is_alpha;
  assign num_ofs   = char_code - CH_ZERO;
  assign alpha_ofs = char_code - CH_A_OFS;
  assign dval      = is_num ? num_ofs[5:0] : (is_alpha ? alpha_ofs[5:0] : 6'd0);

  assign open_win = ((phase == PH_START) && !is_blank) ||
                    ((phase == PH_AFTER) && is_digit);

  always_comb begin
    // a fresh window starts from cleared flags and accumulators
    base_cnt   = open_win ? 3'd0 : digit_count;
    base_x     = open_win ? '0 : acc_x;
    base_y     = open_win ? '0 : acc_y;
    base_blank = open_win ? 1'b0 : saw_blank;
    base_bad   = open_win ? 1'b0 : saw_bad_char;
    base_cont  = open_win ? (phase == PH_AFTER) : window_continues;

    a_blank = base_blank || is_blank;
    a_bad   = base_bad || (!is_blank && !is_digit);
    a_cnt   = base_cnt + 3'd1;
    a_x     = (base_cnt < 3'd2) ? mac36(base_x, dval) : base_x;
    a_y     = (base_cnt < 3'd2) ? base_y : mac36(base_y, dval);
  end

  always_comb begin
    phase_next            = phase;
    digit_count_next      = digit_count;
    acc_x_next            = acc_x;
    acc_y_next            = acc_y;
    prev_x_next           = prev_x;
    prev_y_next           = prev_y;
    saw_blank_next        = saw_blank;
    saw_bad_char_next     = saw_bad_char;
    window_continues_next = window_continues;
    do_absorb             = 1'b0;
    seg                   = 1'b0;

    unique case (phase)
      PH_START:  do_absorb = !is_blank;
      PH_WINDOW: do_absorb = 1'b1;
      PH_AFTER: begin
        if (is_blank) begin
          phase_next = PH_START;
        end else if (is_digit) begin
          do_absorb = 1'b1;
        end else begin
          phase_next        = PH_FAILED;
          saw_blank_next    = 1'b0;
          saw_bad_char_next = 1'b1;
        end
      end
      PH_FAILED: ;
      default: ;
    endcase

    if (do_absorb) begin
      phase_next            = PH_WINDOW;
      digit_count_next      = a_cnt;
      acc_x_next            = a_x;
      acc_y_next            = a_y;
      saw_blank_next        = a_blank;
      saw_bad_char_next     = a_bad;
      window_continues_next = base_cont;
      if (a_cnt == 3'd4) begin
        if (a_blank || a_bad) begin
          phase_next        = PH_FAILED;
          saw_bad_char_next = a_blank ? 1'b0 : a_bad;
        end else if ((a_x > max_x) || (a_y > max_y)) begin
          phase_next        = PH_FAILED;
          saw_blank_next    = 1'b0;
          saw_bad_char_next = 1'b0;
        end else begin
          seg         = base_cont;
          prev_x_next = a_x;
          prev_y_next = a_y;
          phase_next  = PH_AFTER;
        end
      end
    end

    r_seg = '{kind: KIND_SEG, start_x: prev_x, start_y: prev_y, stop_x: a_x,
              stop_y: a_y, error_code: ERR_EARLY_END, last_of_run: 1'b0};
    r_end = '{kind: KIND_DONE, start_x: '0, start_y: '0, stop_x: '0,
              stop_y: '0, error_code: ERR_EARLY_END, last_of_run: 1'b1};
    if (phase_next == PH_WINDOW) begin
      r_end.kind = KIND_ERROR;
    end else if (phase_next == PH_FAILED) begin
      r_end.kind       = KIND_ERROR;
      r_end.error_code = saw_blank_next ? ERR_BLANK :
                         (saw_bad_char_next ? ERR_BAD_CHAR : ERR_BOUNDS);
    end

    push = '0;
    if (take) begin
      if (seg && end_of_text) begin
        push.count  = 2'd2;
        push.first  = r_seg;
        push.second = r_end;
      end else if (seg) begin
        push.count             = 2'd1;
        push.first             = r_seg;
        push.first.last_of_run = 1'b1;
      end else if (end_of_text) begin
        push.count = 2'd1;
        push.first = r_end;
      end
    end

    // end of text: drop everything back to the reset state
    if (end_of_text) begin
      phase_next            = PH_START;
      digit_count_next      = '0;
      acc_x_next            = '0;
      acc_y_next            = '0;
      prev_x_next           = '0;
      prev_y_next           = '0;
      saw_blank_next        = 1'b0;
      saw_bad_char_next     = 1'b0;
      window_continues_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      digit_count      <= '0;
      acc_x            <= '0;
      acc_y            <= '0;
      prev_x           <= '0;
      prev_y           <= '0;
      saw_blank        <= 1'b0;
      saw_bad_char     <= 1'b0;
      window_continues <= 1'b0;
    end else if (take) begin
      phase            <= phase_next;
      digit_count      <= digit_count_next;
      acc_x            <= acc_x_next;
      acc_y            <= acc_y_next;
      prev_x           <= prev_x_next;
      prev_y           <= prev_y_next;
      saw_blank        <= saw_blank_next;
      saw_bad_char     <= saw_bad_char_next;
      window_continues <= window_continues_next;
    end
  end

  assign status.phase   = phase;
  assign status.seg_out = seg;

endmodule

@@ rtl/bpp_out_queue.sv @@
// ----------------------------------------------------------------------------
// bpp_out_queue
// Small result queue taking up to two results per cycle, one out per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpp_out_queue #(
  parameter int DEPTH = bpp_pkg::OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  bpp_pkg::push_t    push,
  input  logic              pop,
  output logic              has_room,
  output logic              not_empty,
  output bpp_pkg::result_t  head
);
  import bpp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next, wr_ptr1, wr_ptr2;
  logic [CW-1:0] fill, fill_next;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr1 = inc(wr_ptr);
  assign wr_ptr2 = inc(wr_ptr1);

  always_comb begin
    unique case (push.count)
      2'd1:    wr_ptr_next = wr_ptr1;
      2'd2:    wr_ptr_next = wr_ptr2;
      default: wr_ptr_next = wr_ptr;
    endcase
    rd_ptr_next = pop ? inc(rd_ptr) : rd_ptr;
    fill_next   = fill + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  // keep room for the worst case of two results from one byte
  assign has_room  = (fill <= CW'(DEPTH - 2));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

endmodule

@@ rtl/base36_polyline_parser_unit.sv @@
// A result enters the result queue as its byte is accepted and goes out on m_axis,
//   one result per beat, once earlier results are gone. One byte is taken per cycle
//   if s_axis_tready is high; a segment-closing last byte queues two results.
// s_axis_tready falls when the four-entry result queue cannot take two more.
// Reset (rst, synchronous) clears parse state and queue; max_x/max_y go to 800/600.
// ----------------------------------------------------------------------------
// base36_polyline_parser_unit
// Reads base-36 point text and streams segments and end-of-text reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module base36_polyline_parser_unit #(
  parameter int OUT_DEPTH = bpp_pkg::OUT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bpp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] char_code
  input  logic                              s_axis_tlast,  // end_of_text
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] kind, [12:2] start_x, [23:13] start_y, [34:24] stop_x,
  // [45:35] stop_y, [47:46] error_code
  output logic [bpp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,  // last_of_run
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bpp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bpp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import bpp_pkg::*;

  logic [COORD_W-1:0] max_x, max_y;
  logic               take, pop, has_room, not_empty;
  push_t              push;
  core_status_t       status;
  result_t            head;

  bpp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_x   (max_x),
    .max_y   (max_y)
  );

  assign s_axis_tready = has_room;
  assign take          = s_axis_tvalid && s_axis_tready;

  bpp_parse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .char_code   (s_axis_tdata[7:0]),
    .end_of_text (s_axis_tlast),
    .max_x       (max_x),
    .max_y       (max_y),
    .push        (push),
    .status      (status)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  bpp_out_queue #(.DEPTH(OUT_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .has_room  (has_room),
    .not_empty (not_empty),
    .head      (head)
  );

  assign m_axis_tvalid = not_empty;
  assign m_axis_tdata  = {head.error_code, head.stop_y, head.stop_x,
                          head.start_y, head.start_x, head.kind};
  assign m_axis_tlast  = head.last_of_run;

  `ASSERT_NEXT(a_eot_restarts, clk, rst, take && s_axis_tlast, status.phase == PH_START)
  `ASSERT_IMPLIES(a_failed_no_seg, clk, rst, status.phase == PH_FAILED, !status.seg_out)
  `ASSERT_IMPLIES(a_report_is_last, clk, rst, m_axis_tvalid && (head.kind != KIND_SEG), m_axis_tlast)

endmodule
